@@ hw/rtl/xml_escape_encoder_top_assert.svh @@
// assertion macros shared by the encoder checks
`ifndef XML_ESCAPE_ENCODER_TOP_ASSERT_SVH
`define XML_ESCAPE_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define XEE_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("xee check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define XEE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("xee check failed: next-cycle implication");

`endif

@@ hw/rtl/xee_pkg.sv @@
// shared types, codes and entity tables for the xml escape encoder
package xee_pkg;

  // escape mode codes
  localparam logic [2:0] MODE_ATTR_SQ = 3'd0;
  localparam logic [2:0] MODE_ATTR_DQ = 3'd1;
  localparam logic [2:0] MODE_TEXT    = 3'd2;
  localparam logic [2:0] MODE_FULL    = 3'd3;
  localparam logic [2:0] MODE_CDATA   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_RESET   = MODE_TEXT;

  // characters of interest
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  // what the back end emits for one input byte
  typedef enum logic [2:0] {
    K_BYTE,
    K_LT,
    K_AMP,
    K_APOS,
    K_QUOT,
    K_GT
  } kind_t;

  // one queued item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       flag;
  } xee_entry_t;

  // run length per kind
  function automatic logic [2:0] entity_len(input kind_t kind);
    logic [2:0] len;
    case (kind)
      K_LT:    len = 3'd4;
      K_GT:    len = 3'd4;
      K_AMP:   len = 3'd5;
      K_APOS:  len = 3'd6;
      K_QUOT:  len = 3'd6;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // byte at position idx of the run
  function automatic logic [7:0] entity_char(input kind_t kind, input logic [2:0] idx,
                                             input logic [7:0] data);
    logic [7:0] ch;
    ch = CH_SEMI;
    if (kind == K_BYTE) begin
      ch = data;
    end else if (idx == 3'd0) begin
      ch = CH_AMP;
    end else begin
      case (kind)
        K_LT:    ch = (idx == 3'd1) ? 8'h6c : (idx == 3'd2) ? 8'h74 : CH_SEMI;
        K_GT:    ch = (idx == 3'd1) ? 8'h67 : (idx == 3'd2) ? 8'h74 : CH_SEMI;
        K_AMP: begin
          case (idx)
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6d;
            3'd3:    ch = 8'h70;
            default: ch = CH_SEMI;
          endcase
        end
        K_APOS: begin
          case (idx)
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h70;
            3'd3:    ch = 8'h6f;
            3'd4:    ch = 8'h73;
            default: ch = CH_SEMI;
          endcase
        end
        K_QUOT: begin
          case (idx)
            3'd1:    ch = 8'h71;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h6f;
            3'd4:    ch = 8'h74;
            default: ch = CH_SEMI;
          endcase
        end
        default: ch = data;
      endcase
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/xee_front.sv @@
// front end: accepts bytes, tracks sequences and classifies each byte
module xee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2:0]        mode,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_string_start,
  input  logic              q_full,
  output logic              push,
  output xee_pkg::xee_entry_t push_entry
);
  import xee_pkg::*;

  logic [1:0] trk_r;
  logic [1:0] trk_nxt;
  logic [1:0] trk_cur;
  kind_t      kind;
  logic       flag;

  assign push = in_valid && !q_full;

  // classification and tracker update
  always_comb begin
    trk_cur = in_string_start ? 2'd0 : trk_r;
    trk_nxt = 2'd0;
    kind    = K_BYTE;
    flag    = 1'b0;
    case (mode)
      MODE_ATTR_SQ: begin
        if (in_data_byte == CH_LT)        kind = K_LT;
        else if (in_data_byte == CH_AMP)  kind = K_AMP;
        else if (in_data_byte == CH_APOS) kind = K_APOS;
      end
      MODE_ATTR_DQ: begin
        if (in_data_byte == CH_LT)        kind = K_LT;
        else if (in_data_byte == CH_AMP)  kind = K_AMP;
        else if (in_data_byte == CH_QUOT) kind = K_QUOT;
      end
      MODE_TEXT: begin
        if (in_data_byte == CH_RBRK) begin
          trk_nxt = (trk_cur >= 2'd2) ? 2'd2 : trk_cur + 2'd1;
        end else if (in_data_byte == CH_GT && trk_cur >= 2'd2) begin
          kind = K_GT;
        end else if (in_data_byte == CH_LT) begin
          kind = K_LT;
        end else if (in_data_byte == CH_AMP) begin
          kind = K_AMP;
        end
      end
      MODE_FULL: begin
        if (in_data_byte == CH_AMP)       kind = K_AMP;
        else if (in_data_byte == CH_LT)   kind = K_LT;
        else if (in_data_byte == CH_GT)   kind = K_GT;
        else if (in_data_byte == CH_APOS) kind = K_APOS;
        else if (in_data_byte == CH_QUOT) kind = K_QUOT;
      end
      MODE_CDATA: begin
        if (in_data_byte == CH_RBRK) begin
          trk_nxt = (trk_cur >= 2'd2) ? 2'd2 : trk_cur + 2'd1;
        end else if (in_data_byte == CH_GT && trk_cur >= 2'd2) begin
          flag = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (in_data_byte == CH_DASH) begin
          flag    = (trk_cur >= 2'd1);
          trk_nxt = 2'd1;
        end
      end
      default: begin
        trk_nxt = 2'd0;
      end
    endcase
  end

  assign push_entry = '{kind: kind, data: in_data_byte, flag: flag};

  // tracker moves only on a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r <= 2'd0;
    end else if (push) begin
      trk_r <= trk_nxt;
    end
  end

endmodule

@@ hw/rtl/xee_fifo.sv @@
// small queue between front and back ends
module xee_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  xee_pkg::xee_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output xee_pkg::xee_entry_t head
);
  import xee_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  xee_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/xee_back.sv @@
// back end: expands queued items into byte runs behind an output register
module xee_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  xee_pkg::xee_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_run_last,
  output logic                out_forbidden_seen
);
  import xee_pkg::*;

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_flag_r;
  logic       load;
  logic       last;
  logic [2:0] len;

  assign len   = entity_len(q_head.kind);
  assign last  = (idx_r == len - 3'd1);
  assign load  = !q_empty && (!out_valid_r || !out_stall);
  assign q_pop = load && last;

  // run position counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= !q_empty;
      end
      if (load) begin
        idx_r <= last ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= entity_char(q_head.kind, idx_r, q_head.data);
      out_last_r <= last;
      out_flag_r <= q_head.flag;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_run_last       = out_last_r;
  assign out_forbidden_seen = out_flag_r;

endmodule

@@ hw/rtl/xml_escape_encoder_top.sv @@
// top level of the xml escape encoder
// Path: an accepted input byte goes through the queue and then the output register.
// Throughput: one input byte per cycle while each maps to one output byte and out_stall is
// low; an entity stays queued until its last byte, and a full queue stalls the input.
// Reset: synchronous active-low rst_n clears the tracker, queue and output valid, and sets
// escape mode to text.
module xml_escape_encoder_top #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_string_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_forbidden_seen
);
  import xee_pkg::*;

  logic [2:0] mode_r;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       push;
  xee_entry_t push_entry;
  xee_entry_t q_head;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;

  xee_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (mode_r),
    .in_valid        (in_valid),
    .in_data_byte    (in_data_byte),
    .in_string_start (in_string_start),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  xee_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  xee_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte           (out_byte),
    .out_run_last       (out_run_last),
    .out_forbidden_seen (out_forbidden_seen)
  );

endmodule

@@ hw/rtl/xee_checker.sv @@
// port-level checks for the xml escape encoder and their bind
`include "xml_escape_encoder_top_assert.svh"

module xee_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_forbidden_seen
);
  import xee_pkg::*;

  logic flag_char_ok;

  // only a greater-than or a dash can complete a forbidden sequence
  assign flag_char_ok = (out_byte == CH_GT) || (out_byte == CH_DASH);

  // a stalled result stays offered
  `XEE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // a flag only ever lands on the closing byte of a run
  `XEE_ASSERT_IMPL(a_flag_last, clk, rst_n, out_valid && out_forbidden_seen, out_run_last)
  // a flagged byte is a greater-than or a dash
  `XEE_ASSERT_IMPL(a_flag_char, clk, rst_n, out_valid && out_forbidden_seen, flag_char_ok)
  // an entity run continues without a gap and never restarts with an ampersand
  `XEE_ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && !out_stall && !out_run_last, out_valid && (out_byte != CH_AMP))

endmodule

bind xml_escape_encoder_top xee_checker u_xee_checker (.*);

@@ test/xml_escape_encoder_top_tb.sv @@
// testbench for the xml escape encoder: directed and random strings against a predictor
module xml_escape_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xee_pkg::*;

  // mode codes with no name in the package
  localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

  localparam int PHASE_ITEMS = 28;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int MAX_PRINTED = 40;

  // one output byte as the encoder should send it
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       flag;
  } escaped_byte_t;

  // predicts the escaped byte runs and checks them in order
  class escape_scoreboard;
    logic [2:0]    mode;
    logic [1:0]    run_count;
    escaped_byte_t pending_bytes[$];
    int unsigned   mismatches;

    function new();
      mode = MODE_RESET;
      run_count = 2'd0;
      mismatches = 0;
    endfunction

    function void set_mode(logic [2:0] m);
      mode = m;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // work out the run for one accepted byte and queue it
    function void add_input(logic [7:0] c, logic start);
      string         ent;
      bit            flag;
      escaped_byte_t eb;
      ent = "";
      flag = 1'b0;
      if (start) run_count = 2'd0;
      case (mode)
        MODE_ATTR_SQ: begin
          run_count = 2'd0;
          if (c == CH_LT) ent = "&lt;";
          else if (c == CH_AMP) ent = "&amp;";
          else if (c == CH_APOS) ent = "&apos;";
        end
        MODE_ATTR_DQ: begin
          run_count = 2'd0;
          if (c == CH_LT) ent = "&lt;";
          else if (c == CH_AMP) ent = "&amp;";
          else if (c == CH_QUOT) ent = "&quot;";
        end
        MODE_TEXT: begin
          // a > after two or more ] closes a cdata-like end and is escaped
          if (c == CH_RBRK) begin
            if (run_count < 2'd2) run_count++;
          end else if (c == CH_GT && run_count >= 2'd2) begin
            run_count = 2'd0;
            ent = "&gt;";
          end else begin
            run_count = 2'd0;
            if (c == CH_LT) ent = "&lt;";
            else if (c == CH_AMP) ent = "&amp;";
          end
        end
        MODE_FULL: begin
          run_count = 2'd0;
          if (c == CH_AMP) ent = "&amp;";
          else if (c == CH_LT) ent = "&lt;";
          else if (c == CH_GT) ent = "&gt;";
          else if (c == CH_APOS) ent = "&apos;";
          else if (c == CH_QUOT) ent = "&quot;";
        end
        MODE_CDATA: begin
          if (c == CH_RBRK) begin
            if (run_count < 2'd2) run_count++;
          end else if (c == CH_GT && run_count >= 2'd2) begin
            run_count = 2'd0;
            flag = 1'b1;
          end else begin
            run_count = 2'd0;
          end
        end
        MODE_COMMENT: begin
          // every dash after the first in a run of dashes is flagged
          if (c == CH_DASH) begin
            flag = (run_count >= 2'd1);
            run_count = 2'd1;
          end else begin
            run_count = 2'd0;
          end
        end
        default: begin
          run_count = 2'd0;
        end
      endcase
      if (ent.len() == 0) begin
        eb.data = c;
        eb.last = 1'b1;
        eb.flag = flag;
        pending_bytes.push_back(eb);
      end else begin
        for (int i = 0; i < ent.len(); i++) begin
          eb.data = ent[i];
          eb.last = (i == ent.len() - 1);
          eb.flag = 1'b0;
          pending_bytes.push_back(eb);
        end
      end
    endfunction

    // compare one output transfer with the oldest expected byte
    task check_byte(logic [7:0] data, logic last, logic flag);
      escaped_byte_t eb;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", data));
      end else begin
        eb = pending_bytes.pop_front();
        if (data !== eb.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", data, eb.data));
        if (last !== eb.last)
          report_mismatch($sformatf("run_last %b, want %b on byte %02h", last, eb.last,
                                    eb.data));
        if (flag !== eb.flag)
          report_mismatch($sformatf("forbidden_seen %b, want %b on byte %02h", flag,
                                    eb.flag, eb.data));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_wr_data = 3'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_string_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_forbidden_seen;

  escape_scoreboard sb = new();
  bit               no_idle = 1'b0;
  bit               long_hold = 1'b0;
  int               items_sent = 0;

  xml_escape_encoder_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_string_start   (in_string_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_forbidden_seen(out_forbidden_seen)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // offer one byte after a random gap and wait for its transfer
  task send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_string_start <= st;
    do @(posedge clk); while (in_stall);
    sb.add_input(b, st);
    items_sent++;
  endtask

  task send_string(input string s, input logic start_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], start_first && (i == 0));
  endtask

  // mode write once every expected byte has come out
  task write_mode(input logic [2:0] m);
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    sb.set_mode(m);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1:    c = CH_RBRK;
      2:       c = CH_GT;
      3:       c = CH_DASH;
      4:       c = CH_LT;
      5:       c = CH_AMP;
      6:       c = CH_APOS;
      7:       c = CH_QUOT;
      8, 9:    c = 8'($urandom_range(0, 255));
      default: c = 8'h61 + 8'($urandom_range(0, 25));
    endcase
    return c;
  endfunction

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_byte(out_byte, out_run_last, out_forbidden_seen);
    end
  end

  // stimulus
  initial begin : stimulus
    string      frags[6];
    logic [2:0] phase_mode[8];
    logic [2:0] m;
    int         phase_start;
    frags = '{"]]>", "]]]>", "--", "---", "]>", "]]"};
    phase_mode = '{MODE_TEXT, MODE_CDATA, MODE_COMMENT, MODE_FULL, MODE_ATTR_SQ,
                   MODE_ATTR_DQ, MODE_UNUSED_7, MODE_CDATA};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // text mode out of reset: bracket runs, reserved characters, byte extremes
    send_string("]]]>", 1'b1);
    send_string("]>", 1'b0);
    send_byte(CH_AMP, 1'b0);
    send_byte(CH_LT, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    // cdata check with an extra bracket
    write_mode(MODE_CDATA);
    send_string("]]]>", 1'b1);
    // comment check with a run of dashes
    write_mode(MODE_COMMENT);
    send_string("---", 1'b1);
    // full escaping of the remaining characters
    write_mode(MODE_FULL);
    send_byte(CH_APOS, 1'b1);
    send_byte(CH_QUOT, 1'b0);
    send_byte(CH_GT, 1'b0);
    write_mode(MODE_ATTR_SQ);
    send_byte(CH_APOS, 1'b1);
    write_mode(MODE_ATTR_DQ);
    send_byte(CH_QUOT, 1'b1);
    // unused mode passes everything through
    write_mode(MODE_UNUSED_6);
    send_byte(CH_LT, 1'b1);

    // random phases, strings may run on across a mode change
    for (int p = 0; p < 11; p++) begin
      m = (p < 8) ? phase_mode[p] : 3'($urandom_range(0, 7));
      write_mode(m);
      no_idle = (p == 3 || p == 7);
      if (p == 0 || p == 3) long_hold = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0)
          send_string(frags[$urandom_range(0, 5)], $urandom_range(0, 5) == 0);
        else
          send_byte(pick_char(), $urandom_range(0, 7) == 0);
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    // drain and let the pipeline settle
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ xml_escape_encoder_top.f @@
+incdir+hw/rtl
hw/rtl/xee_pkg.sv
hw/rtl/xee_front.sv
hw/rtl/xee_fifo.sv
hw/rtl/xee_back.sv
hw/rtl/xml_escape_encoder_top.sv
hw/rtl/xee_checker.sv
test/xml_escape_encoder_top_tb.sv
